[sv/dnle_pkg.sv]
// Shared types and constants for the DNS name label encoder.
// No dependencies; used by every module of the block.
package dnle_pkg;

  localparam int BYTE_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int NAME_COUNT_W = 9;

  localparam logic [NAME_COUNT_W-1:0] NAME_COUNT_TOP = 9'd511;

  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;
  localparam logic [BYTE_W-1:0] END_CHAR = 8'h00;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_DOT     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NAME_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_LABEL_LONG = 2'd3;

  localparam logic CMD_LABEL = 1'b0;
  localparam logic CMD_END   = 1'b1;

  // Work handed from the front to the back.
  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   len;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                end_of_name;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

[sv/dnle_front.sv]
// Front end: accepts characters, tracks label/name counts and errors,
// holds the label store and issues label/end commands. Uses dnle_pkg.
module dnle_front #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255,
  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1,
  localparam int CW = $clog2(LABEL_MAX + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [dnle_pkg::BYTE_W-1:0] char_code,
  output logic                        full,
  output logic                        cmd_push,
  output dnle_pkg::cmd_t              cmd,
  input  logic                        cmd_full,
  input  logic                        label_done,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [dnle_pkg::BYTE_W-1:0] rd_data
);

  logic [dnle_pkg::BYTE_W-1:0]       store [LABEL_MAX];
  logic [CW-1:0]                     label_count;
  logic [dnle_pkg::NAME_COUNT_W-1:0] name_count;
  logic                              prev_dot;
  logic                              err_name;
  logic                              err_label;
  logic                              busy;

  logic accept;
  logic is_end;
  logic is_dot;
  logic err_name_upd;
  logic label_full;
  logic emit;
  logic wr_en;

  // Single label store: hold off input while the back drains it.
  assign full   = busy || cmd_full;
  assign accept = push && !full;
  assign is_end = (char_code == dnle_pkg::END_CHAR);
  assign is_dot = (char_code == dnle_pkg::DOT_CHAR);

  assign err_name_upd = err_name ||
                        (name_count >= dnle_pkg::NAME_COUNT_W'(NAME_MAX));
  assign label_full   = (label_count >= CW'(LABEL_MAX));
  assign emit  = accept && is_dot && !err_name_upd && !err_label &&
                 (label_count != '0);
  assign wr_en = accept && !is_end && !is_dot && !label_full;

  assign cmd_push = emit || (accept && is_end);

  always_comb begin
    cmd.kind   = is_end ? dnle_pkg::CMD_END : dnle_pkg::CMD_LABEL;
    cmd.len    = dnle_pkg::BYTE_W'(label_count);
    cmd.status = dnle_pkg::STATUS_OK;
    if ((name_count != '0) && !prev_dot) begin
      cmd.status = dnle_pkg::STATUS_NO_DOT;
    end else if (err_name) begin
      cmd.status = dnle_pkg::STATUS_NAME_LONG;
    end else if (err_label) begin
      cmd.status = dnle_pkg::STATUS_LABEL_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[label_count[AW-1:0]] <= char_code;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= '0;
      name_count  <= '0;
      prev_dot    <= 1'b0;
      err_name    <= 1'b0;
      err_label   <= 1'b0;
      busy        <= 1'b0;
    end else begin
      busy <= (busy && !label_done) || emit;
      if (accept) begin
        if (is_end) begin
          label_count <= '0;
          name_count  <= '0;
          prev_dot    <= 1'b0;
          err_name    <= 1'b0;
          err_label   <= 1'b0;
        end else begin
          err_name <= err_name_upd;
          if (name_count != dnle_pkg::NAME_COUNT_TOP) begin
            name_count <= name_count + 1'b1;
          end
          if (is_dot) begin
            prev_dot    <= 1'b1;
            label_count <= '0;
          end else begin
            prev_dot <= 1'b0;
            if (label_full) begin
              err_label <= 1'b1;
            end else begin
              label_count <= label_count + 1'b1;
            end
          end
        end
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into a full queue");

  a_read_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> busy)
    else $error("label store read with no label outstanding");

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy)
    else $error("label store written while the back reads it");

endmodule

[sv/dnle_cmd_q.sv]
// Two-entry command queue between front and back.
// Uses dnle_pkg::cmd_t.
module dnle_cmd_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  dnle_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output dnle_pkg::cmd_t rd_data,
  output logic           q_valid
);

  dnle_pkg::cmd_t entries [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[sv/dnle_back.sv]
// Back end: turns commands into wire bytes, reading the label store,
// through an issue stage and a four-entry result queue. Uses dnle_pkg.
module dnle_back #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  dnle_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic                          label_done,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic [dnle_pkg::BYTE_W-1:0]   rd_data,
  input  logic                          pop,
  output logic                          empty,
  output logic [dnle_pkg::BYTE_W-1:0]   out_byte,
  output logic                          end_of_name,
  output logic [dnle_pkg::STATUS_W-1:0] status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                          state;
  logic [AW-1:0]                 idx;
  logic [dnle_pkg::BYTE_W-1:0]   len;

  logic                          s_valid;
  logic                          s_is_mem;
  logic [dnle_pkg::BYTE_W-1:0]   s_byte;
  logic                          s_eon;
  logic [dnle_pkg::STATUS_W-1:0] s_status;

  dnle_pkg::result_t             ofifo [4];
  logic [1:0]                    owptr;
  logic [1:0]                    orptr;
  logic [2:0]                    ocount;

  logic              room;
  logic              last;
  logic              opop;
  dnle_pkg::result_t opush_data;

  // Room counts the item still in the issue stage.
  assign room    = (ocount + {2'b00, s_valid}) < 3'd4;
  assign cmd_pop = (state == ST_IDLE) && cmd_valid && room;
  assign rd_en   = (state == ST_READ) && room;
  assign rd_addr = idx;
  assign last    = (dnle_pkg::BYTE_W'(idx) == (len - 1'b1));
  assign label_done = rd_en && last;

  assign opop  = pop && !empty;
  assign empty = (ocount == 3'd0);

  always_comb begin
    opush_data.out_byte    = s_is_mem ? rd_data : s_byte;
    opush_data.end_of_name = s_eon;
    opush_data.status      = s_status;
  end

  assign out_byte    = ofifo[orptr].out_byte;
  assign end_of_name = ofifo[orptr].end_of_name;
  assign status      = ofifo[orptr].status;

  always_ff @(posedge clk) begin
    s_is_mem <= rd_en;
    s_byte   <= (cmd.kind == dnle_pkg::CMD_END) ? '0 : cmd.len;
    s_eon    <= cmd_pop && (cmd.kind == dnle_pkg::CMD_END);
    s_status <= (cmd_pop && (cmd.kind == dnle_pkg::CMD_END)) ?
                cmd.status : dnle_pkg::STATUS_OK;
    if (s_valid) begin
      ofifo[owptr] <= opush_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      len     <= '0;
      s_valid <= 1'b0;
      owptr   <= '0;
      orptr   <= '0;
      ocount  <= '0;
    end else begin
      s_valid <= cmd_pop || rd_en;
      if (s_valid) begin
        owptr <= owptr + 1'b1;
      end
      if (opop) begin
        orptr <= orptr + 1'b1;
      end
      ocount <= ocount + {2'b00, s_valid} - {2'b00, opop};
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop && (cmd.kind == dnle_pkg::CMD_LABEL)) begin
            state <= ST_READ;
            idx   <= '0;
            len   <= cmd.len;
          end
        end
        ST_READ: begin
          if (rd_en) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_stage_has_room: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> (ocount < 3'd4) || opop)
    else $error("result pushed into a full result queue");

  a_label_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (len != '0))
    else $error("draining a label of length zero");

  a_mem_item_not_end: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_is_mem) |-> !s_eon)
    else $error("label byte marked as end of name");

endmodule

[sv/dns_name_label_encoder_top.sv]
// DNS name wire encoder. Characters enter one per cycle while full is low; a
// character is stored in the label store, and a dot hands the label to the
// back end, which emits the length byte and the label bytes at one byte per
// cycle while the result queue has room. There is one label store, so input
// is held off (full) from a dot that emits until the last byte of that label
// is read. The zero character yields the terminating zero with its status.
// Results sit in a four-entry queue, so the consumer may stall freely.
// Depends on dnle_pkg, dnle_front, dnle_cmd_q and dnle_back.
module dns_name_label_encoder_top #(
  parameter int LABEL_MAX = 63,
  parameter int NAME_MAX  = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [dnle_pkg::BYTE_W-1:0]   char_code,
  output logic                          empty,
  input  logic                          pop,
  output logic [dnle_pkg::BYTE_W-1:0]   out_byte,
  output logic                          end_of_name,
  output logic [dnle_pkg::STATUS_W-1:0] status
);

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  logic                        cmd_push;
  dnle_pkg::cmd_t              cmd_in;
  logic                        cmd_full;
  logic                        cmd_pop;
  dnle_pkg::cmd_t              cmd_out;
  logic                        cmd_valid;
  logic                        label_done;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [dnle_pkg::BYTE_W-1:0] rd_data;

  dnle_front #(
    .LABEL_MAX (LABEL_MAX),
    .NAME_MAX  (NAME_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .char_code  (char_code),
    .full       (full),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full),
    .label_done (label_done),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  dnle_cmd_q u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .q_full  (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .q_valid (cmd_valid)
  );

  dnle_back #(
    .AW (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd_out),
    .cmd_pop     (cmd_pop),
    .label_done  (label_done),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .end_of_name (end_of_name),
    .status      (status)
  );

endmodule
